// File: rtl/dcc_pkg.sv
// Shared types and constants for the DTMF command collector.
// Used by front, back, top and benches; depends on nothing.
`timescale 1ns / 1ps
package dcc_pkg;

  // Default buffer depth and timeout
  localparam int DCC_MAX_DIGITS = 20;
  localparam logic [19:0] DCC_TIMEOUT_RESET = 20'd10000;

  // Input modes
  localparam logic [1:0] MODE_SYMBOL = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_FORCE  = 2'd2;

  // Symbol codes
  localparam logic [4:0] SYM_STAR = 5'd10;
  localparam logic [4:0] SYM_HASH = 5'd11;
  localparam logic [4:0] SYM_A    = 5'd12;
  localparam logic [4:0] SYM_B    = 5'd13;
  localparam logic [4:0] SYM_C    = 5'd14;
  localparam logic [4:0] SYM_D    = 5'd15;
  localparam logic [4:0] SYM_H    = 5'd16;
  localparam logic [4:0] SYM_LAST_DIGIT = 5'd9;

  // Buffer bank release from back end to front end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

// File: rtl/dcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
module dcc_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/dcc_front.sv
// Front end: accepts requests, keeps the collection state and timer,
// writes symbols into the ping-pong buffer and queues finished commands.
// Depends on dcc_pkg.
`timescale 1ns / 1ps
module dcc_front
  import dcc_pkg::*;
#(
  parameter int MAX_DIGITS = DCC_MAX_DIGITS,
  localparam int CW = $clog2(MAX_DIGITS + 1),
  localparam int AW = $clog2(2 * MAX_DIGITS),
  localparam int QW = CW + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    mode,
  input  logic [4:0]    symbol,
  input  logic          cfg_wr_en,
  input  logic [19:0]   cfg_wr_data,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [3:0]    ram_wdata,
  output logic          q_push,
  output logic [QW-1:0] q_din,
  input  logic          q_full,
  input  rel_t          rel
);

  // Collection state
  logic [19:0]   timeout;
  logic [CW-1:0] count, count_next;
  logic          guard, guard_next;
  logic [3:0]    prev, prev_next;
  logic          pv, pv_next;
  logic          first_star, first_star_next;
  logic          running, running_next;
  logic [19:0]   idle, idle_next;
  logic          bank, bank_next;
  logic [1:0]    busy, busy_next;

  logic          accept;
  logic          complete;
  logic          app;
  logic [3:0]    app_sym;
  logic          restart;
  logic [CW-1:0] base_cnt;
  logic [19:0]   idle_inc;
  logic          star_ok;

  assign in_ready = !q_full && !busy[bank];
  assign accept   = in_valid && in_ready;
  assign idle_inc = (idle != '1) ? idle + 20'd1 : idle;
  assign star_ok  = !(count == CW'(1) && first_star);

  // Classify the request and work out the next state
  always_comb begin
    count_next      = count;
    guard_next      = guard;
    prev_next       = prev;
    pv_next         = pv;
    first_star_next = first_star;
    running_next    = running;
    idle_next       = idle;
    bank_next       = bank;
    busy_next       = busy;
    complete        = 1'b0;
    app             = 1'b0;
    app_sym         = '0;
    restart         = 1'b0;

    if (accept) begin
      case (mode)
        MODE_TICK: begin
          if (running) begin
            if (idle_inc >= timeout) begin
              count_next   = '0;
              guard_next   = 1'b0;
              prev_next    = '0;
              pv_next      = 1'b0;
              running_next = 1'b0;
              idle_next    = '0;
            end else begin
              idle_next = idle_inc;
            end
          end
        end
        MODE_FORCE: begin
          complete = (count != '0);
        end
        MODE_SYMBOL: begin
          idle_next    = '0;
          running_next = 1'b1;
          if (symbol == SYM_HASH || (guard && symbol == SYM_C)) begin
            complete = 1'b1;
          end else if (symbol == SYM_A) begin
            guard_next = 1'b1;
            pv_next    = 1'b0;
          end else if (symbol == SYM_D) begin
            restart = 1'b1;
            app     = 1'b1;
            app_sym = SYM_D[3:0];
            pv_next = 1'b0;
          end else if (count < CW'(MAX_DIGITS)) begin
            if (symbol == SYM_H) begin
              app     = 1'b1;
              app_sym = SYM_HASH[3:0];
            end else if (symbol == SYM_B) begin
              if (guard && pv) begin
                app     = 1'b1;
                app_sym = prev;
                pv_next = 1'b0;
              end
            end else if (symbol <= SYM_LAST_DIGIT || (symbol == SYM_STAR && star_ok)) begin
              if (guard) begin
                if (!pv || prev != symbol[3:0]) begin
                  app       = 1'b1;
                  app_sym   = symbol[3:0];
                  prev_next = symbol[3:0];
                  pv_next   = 1'b1;
                end
              end else begin
                app     = 1'b1;
                app_sym = symbol[3:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Append into the current bank
    base_cnt = restart ? '0 : count;
    if (app) begin
      count_next = base_cnt + CW'(1);
      if (base_cnt == '0) begin
        first_star_next = (app_sym == SYM_STAR[3:0]);
      end
    end

    // Hand a finished command to the back end and clear
    if (complete) begin
      count_next   = '0;
      guard_next   = 1'b0;
      prev_next    = '0;
      pv_next      = 1'b0;
      running_next = 1'b0;
      idle_next    = '0;
      if (count != '0) begin
        bank_next = ~bank;
      end
    end

    // Track which banks the back end still reads
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (complete && count != '0) begin
      busy_next[bank] = 1'b1;
    end
  end

  assign ram_we    = app;
  assign ram_wdata = app_sym;
  assign ram_waddr = AW'(base_cnt) + (bank ? AW'(MAX_DIGITS) : AW'(0));
  assign q_push    = complete;
  assign q_din     = {(count == '0), bank, count};

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= DCC_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout <= cfg_wr_data;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      guard      <= 1'b0;
      prev       <= '0;
      pv         <= 1'b0;
      first_star <= 1'b0;
      running    <= 1'b0;
      idle       <= '0;
      bank       <= 1'b0;
      busy       <= '0;
    end else begin
      count      <= count_next;
      guard      <= guard_next;
      prev       <= prev_next;
      pv         <= pv_next;
      first_star <= first_star_next;
      running    <= running_next;
      idle       <= idle_next;
      bank       <= bank_next;
      busy       <= busy_next;
    end
  end

endmodule

// File: rtl/dcc_queue.sv
// Two-entry queue of finished command descriptors between front and back.
// Standalone; no package dependency.
`timescale 1ns / 1ps
module dcc_queue #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         nempty
);

  logic [W-1:0] entry [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;

  assign full   = (fill == 2'd2);
  assign nempty = (fill != 2'd0);
  assign dout   = entry[rptr];

  // Store pushed descriptor
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= din;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/dcc_back.sv
// Back end: takes command descriptors, reads buffer symbols one per cycle
// unless output stalls and drives the result register. Depends on dcc_pkg.
`timescale 1ns / 1ps
module dcc_back
  import dcc_pkg::*;
#(
  parameter int MAX_DIGITS = DCC_MAX_DIGITS,
  localparam int CW = $clog2(MAX_DIGITS + 1),
  localparam int AW = $clog2(2 * MAX_DIGITS),
  localparam int QW = CW + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [QW-1:0] q_dout,
  input  logic          q_nempty,
  output logic          q_pop,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [3:0]    ram_rdata,
  output rel_t          rel,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    symbol_res,
  output logic          last,
  output logic          empty_command
);

  logic          active;
  logic          cur_bank;
  logic [CW-1:0] cur_idx;
  logic [CW-1:0] cur_count;
  logic          rd_pend;
  logic          rd_last;

  logic          q_empty_cmd;
  logic          q_bank;
  logic [CW-1:0] q_count;
  logic          out_free;
  logic          load_rd;
  logic          pop_empty;
  logic          pop_cmd;
  logic          issue;
  logic          issue_last;

  assign {q_empty_cmd, q_bank, q_count} = q_dout;

  assign out_free   = !out_valid || out_ready;
  assign load_rd    = rd_pend && out_free;
  assign pop_empty  = !active && q_nempty && q_empty_cmd && !rd_pend && out_free;
  assign pop_cmd    = !active && q_nempty && !q_empty_cmd;
  assign q_pop      = pop_empty || pop_cmd;
  assign issue      = active && (!rd_pend || load_rd);
  assign issue_last = (cur_idx + CW'(1) == cur_count);

  assign ram_re    = issue;
  assign ram_raddr = AW'(cur_idx) + (cur_bank ? AW'(MAX_DIGITS) : AW'(0));

  // Release the bank once its last symbol has been read
  assign rel.valid = issue && issue_last;
  assign rel.bank  = cur_bank;

  // Read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (pop_cmd) begin
        active <= 1'b1;
      end else if (issue && issue_last) begin
        active <= 1'b0;
      end
      if (issue) begin
        rd_pend <= 1'b1;
      end else if (load_rd) begin
        rd_pend <= 1'b0;
      end
    end
  end

  // Command position and read tag
  always_ff @(posedge clk) begin
    if (pop_cmd) begin
      cur_bank  <= q_bank;
      cur_count <= q_count;
      cur_idx   <= '0;
    end else if (issue) begin
      cur_idx <= cur_idx + CW'(1);
    end
    if (issue) begin
      rd_last <= issue_last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_rd || pop_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rd) begin
      symbol_res    <= ram_rdata;
      last          <= rd_last;
      empty_command <= 1'b0;
    end else if (pop_empty) begin
      symbol_res    <= '0;
      last          <= 1'b1;
      empty_command <= 1'b1;
    end
  end

endmodule

// File: rtl/dtmf_command_collector.sv
// Top level of the DTMF command collector: front end, descriptor queue,
// ping-pong symbol buffer and back end. Depends on dcc_pkg and submodules.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, mode, symbol          request in
//   result    out_valid/out_ready, symbol_res, last,   request out
//             empty_command
//   config    cfg_wr_en, cfg_wr_data (timeout_ticks)   write only
//
// The front end takes one request per cycle unless stalled; symbols and
// ticks finish in it. A completion emits its N stored symbols one per cycle
// while results are taken; the first passes queue pop, RAM read, then the
// result register. An empty command passes the queue and result register.
// The front end stalls while both queue slots are taken or while the buffer
// bank it would fill is still being read out. Reset is synchronous and
// needs no clearing pass; the buffer is only read below its fill count.
`timescale 1ns / 1ps
module dtmf_command_collector
  import dcc_pkg::*;
#(
  parameter int MAX_DIGITS = DCC_MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [4:0]  symbol,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  symbol_res,
  output logic        last,
  output logic        empty_command
);

  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int DEPTH = 2 * MAX_DIGITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = CW + 2;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [3:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [3:0]    ram_rdata;
  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] q_din;
  logic [QW-1:0] q_dout;
  logic          q_full;
  logic          q_nempty;
  rel_t          rel;

  // Accept and classify requests
  dcc_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .symbol     (symbol),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .q_push     (q_push),
    .q_din      (q_din),
    .q_full     (q_full),
    .rel        (rel)
  );

  // Finished command descriptors
  dcc_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .nempty(q_nempty)
  );

  // Two banks of command symbols
  dcc_ram #(.W(4), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Read out commands
  dcc_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_dout       (q_dout),
    .q_nempty     (q_nempty),
    .q_pop        (q_pop),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .rel          (rel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_res   (symbol_res),
    .last         (last),
    .empty_command(empty_command)
  );

endmodule

// File: rtl/dcc_checker.sv
// Port-level checks for the DTMF command collector, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
module dcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  mode,
  input logic [4:0]  symbol,
  input logic        cfg_wr_en,
  input logic [19:0] cfg_wr_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  symbol_res,
  input logic        last,
  input logic        empty_command
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol_res) && $stable(last)
      && $stable(empty_command))
    else $error("stalled result changed");

  // Empty command is a single closing result with a zero symbol
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_command |-> last && symbol_res == 4'd0)
    else $error("empty command result malformed");

  // Only digits, star, hash and D are ever stored
  a_sym_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> symbol_res != 4'd12 && symbol_res != 4'd13 && symbol_res != 4'd14)
    else $error("control symbol emitted");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind dtmf_command_collector dcc_checker u_dcc_checker (.*);

// File: bench/dcc_result_checker.sv
// Result checker for the DTMF command collector: tracks collector state from
// accepted requests, predicts every emitted symbol and compares it on output.
// Depends on dcc_pkg.
`timescale 1ns / 1ps
module dcc_result_checker
  import dcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [4:0]  symbol,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  symbol_res,
  input  logic        last,
  input  logic        empty_command,
  output int          fail_count,
  output int          results_seen,
  output int          results_pending
);

  typedef struct packed {
    logic [3:0] sym;
    logic       last_flag;
    logic       empty_flag;
  } cmd_result_t;

  // Predicted collector state
  logic [19:0] timeout_limit;
  logic [3:0]  cmd_buf [DCC_MAX_DIGITS];
  int          buf_count;
  logic        guard_on;
  logic [3:0]  prev_sym;
  logic        prev_ok;
  logic        timer_on;
  logic [19:0] silent_ticks;

  cmd_result_t expected_results [$];

  // Print one line per mismatch, up to 40; keep the log short on a broken run
  task automatic report_mismatch(input string what, input logic [3:0] want,
                                 input logic [3:0] got);
    if (fail_count < 40) begin
      $display("%0t ns: MISMATCH on %s, expected %0d, got %0d (result %0d)",
               $time, what, want, got, results_seen);
    end
    fail_count++;
  endtask

  task automatic clear_partial();
    buf_count = 0;
    guard_on  = 1'b0;
    prev_sym  = '0;
    prev_ok   = 1'b0;
  endtask

  task automatic store_symbol(input logic [3:0] s);
    if (buf_count < DCC_MAX_DIGITS) begin
      cmd_buf[buf_count] = s;
      buf_count++;
    end
  endtask

  // Queue the stored command, or one empty-command result, then clear
  task automatic flush_command();
    cmd_result_t r;
    if (buf_count == 0) begin
      r.sym        = '0;
      r.last_flag  = 1'b1;
      r.empty_flag = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < buf_count; i++) begin
        r.sym        = cmd_buf[i];
        r.last_flag  = (i + 1 == buf_count);
        r.empty_flag = 1'b0;
        expected_results.push_back(r);
      end
    end
    clear_partial();
    timer_on     = 1'b0;
    silent_ticks = '0;
  endtask

  // Advance the predicted state by one accepted request
  task automatic predict_request(input logic [1:0] m, input logic [4:0] s);
    if (m == MODE_TICK) begin
      if (timer_on) begin
        if (silent_ticks != 20'hFFFFF) silent_ticks++;
        if (silent_ticks >= timeout_limit) begin
          clear_partial();
          timer_on     = 1'b0;
          silent_ticks = '0;
        end
      end
    end else if (m == MODE_FORCE) begin
      if (buf_count > 0) flush_command();
    end else if (m == MODE_SYMBOL) begin
      silent_ticks = '0;
      timer_on     = 1'b1;
      if (s == SYM_HASH || (guard_on && s == SYM_C)) begin
        flush_command();
      end else if (s == SYM_A) begin
        guard_on = 1'b1;
        prev_ok  = 1'b0;
      end else if (s == SYM_D) begin
        buf_count = 0;
        store_symbol(SYM_D[3:0]);
        prev_ok = 1'b0;
      end else if (buf_count < DCC_MAX_DIGITS) begin
        if (s == SYM_H) begin
          store_symbol(SYM_HASH[3:0]);
        end else if (s == SYM_B) begin
          if (guard_on && prev_ok) begin
            store_symbol(prev_sym);
            prev_ok = 1'b0;
          end
        end else if (s <= SYM_LAST_DIGIT ||
                     (s == SYM_STAR &&
                      !(buf_count == 1 && cmd_buf[0] == SYM_STAR[3:0]))) begin
          // With anti-flutter on, drop a repeat of the previous symbol
          if (guard_on) begin
            if (!prev_ok || prev_sym != s[3:0]) begin
              store_symbol(s[3:0]);
              prev_sym = s[3:0];
              prev_ok  = 1'b1;
            end
          end else begin
            store_symbol(s[3:0]);
          end
        end
      end
    end
  endtask

  task automatic check_result();
    cmd_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", 4'd0, symbol_res);
    end else begin
      want = expected_results.pop_front();
      // Symbol field carries no meaning on an empty command
      if (!want.empty_flag && symbol_res !== want.sym)
        report_mismatch("symbol_res", want.sym, symbol_res);
      if (last !== want.last_flag)
        report_mismatch("last", {3'b0, want.last_flag}, {3'b0, last});
      if (empty_command !== want.empty_flag)
        report_mismatch("empty_command", {3'b0, want.empty_flag}, {3'b0, empty_command});
    end
    results_seen++;
  endtask

  initial begin
    fail_count      = 0;
    results_seen    = 0;
    results_pending = 0;
  end

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      timeout_limit = DCC_TIMEOUT_RESET;
      clear_partial();
      timer_on     = 1'b0;
      silent_ticks = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) timeout_limit = cfg_wr_data;
      if (in_valid && in_ready) predict_request(mode, symbol);
      if (out_valid && out_ready) check_result();
    end
    results_pending = expected_results.size();
  end

endmodule

// File: bench/dtmf_command_collector_tb.sv
// Testbench top for the DTMF command collector: clock, reset, request and
// result stimulus, timeout register writes and the final verdict.
// Depends on dcc_pkg, dtmf_command_collector and dcc_result_checker.
`timescale 1ns / 1ps
module dtmf_command_collector_tb;
  import dcc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 210;
  localparam int LONG_HOLD    = 400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [4:0]  symbol;
  logic        cfg_wr_en;
  logic [19:0] cfg_wr_data;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  symbol_res;
  logic        last;
  logic        empty_command;

  int mismatches;
  int results_checked;
  int results_pending;

  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold_req;
  int requests_sent;
  int live_requests;
  int settings_used;

  dtmf_command_collector i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .symbol        (symbol),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .symbol_res    (symbol_res),
    .last          (last),
    .empty_command (empty_command)
  );

  dcc_result_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .symbol          (symbol),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .symbol_res      (symbol_res),
    .last            (last),
    .empty_command   (empty_command),
    .fail_count      (mismatches),
    .results_seen    (results_checked),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit with %0d results outstanding",
             results_pending);
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        out_ready = 1'b0;
        repeat (rx_hold_req) @(negedge clk);
        rx_hold_req = 0;
      end
      stall = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid && rx_hold_req == 0);
      @(negedge clk);
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic [1:0] m, input logic [4:0] s);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode     = m;
    symbol   = s;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    requests_sent++;
    if (m != MODE_UNUSED && !(m == MODE_SYMBOL && s > SYM_H)) live_requests++;
  endtask

  task automatic send_symbol(input logic [4:0] s);
    send_request(MODE_SYMBOL, s);
  endtask

  task automatic wait_drained();
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the timeout register once the block has gone idle
  task automatic set_timeout(input logic [19:0] ticks);
    wait_drained();
    cfg_wr_data = ticks;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    settings_used++;
  endtask

  // One command-like run of symbols with random content and ending
  task automatic send_command_run();
    int n;
    int r;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 28) : $urandom_range(0, 8);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50)      send_symbol(5'($urandom_range(0, 9)));
      else if (r < 57) send_symbol(SYM_STAR);
      else if (r < 62) send_symbol(SYM_H);
      else if (r < 68) send_symbol(SYM_A);
      else if (r < 75) send_symbol(SYM_B);
      else if (r < 79) send_symbol(SYM_C);
      else if (r < 82) send_symbol(SYM_D);
      else if (r < 92) send_request(MODE_TICK, 5'($urandom));
      else if (r < 95) begin
        repeat ($urandom_range(1, 10)) send_request(MODE_TICK, 5'($urandom));
      end else begin
        send_request(2'($urandom), 5'($urandom));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_symbol(SYM_HASH);
    end else if (r < 60) begin
      send_symbol(SYM_A);
      send_symbol(SYM_C);
    end else if (r < 80) begin
      send_request(MODE_FORCE, 5'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [19:0] timeout_plan [7];
    int          target;

    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = MODE_SYMBOL;
    symbol        = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    rx_hold_req   = 0;
    requests_sent = 0;
    live_requests = 0;
    settings_used = 0;
    timeout_plan  = '{20'd1, 20'd0, 20'd3, 20'hFFFFF, 20'd7, 20'd20, 20'd2};

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: completion paths and refused symbols at the reset timeout
    send_request(MODE_FORCE, SYM_H);       // force on empty buffer: nothing
    send_symbol(SYM_HASH);                 // empty command
    send_symbol(SYM_STAR);
    send_symbol(SYM_STAR);                 // refused while buffer is "*"
    send_symbol(5'd9);
    send_symbol(5'd0);
    send_symbol(SYM_H);                    // stores hash
    send_symbol(SYM_C);                    // refused, anti-flutter off
    send_symbol(SYM_B);                    // refused, anti-flutter off
    send_symbol(5'd31);                    // out-of-range symbol
    send_request(MODE_UNUSED, 5'd17);      // unused mode
    send_request(MODE_FORCE, 5'd0);        // emits * 9 0 #
    send_symbol(SYM_A);
    send_symbol(5'd5);
    send_symbol(5'd5);                     // repeat dropped
    send_symbol(SYM_B);                    // re-enters 5
    send_symbol(SYM_B);                    // no previous symbol left
    send_symbol(SYM_C);                    // ends command under anti-flutter
    send_symbol(SYM_D);
    send_symbol(5'd3);
    send_symbol(SYM_HASH);                 // emits D 3
    send_symbol(SYM_STAR);
    send_symbol(SYM_D);                    // restart as "D"
    send_symbol(SYM_HASH);

    // Directed: silence timer at the shortest timeout
    set_timeout(20'd1);
    send_symbol(5'd4);
    send_request(MODE_TICK, 5'd0);         // expires, buffer cleared
    send_request(MODE_TICK, 5'd0);         // timer already stopped
    send_request(MODE_FORCE, 5'd0);        // nothing stored
    send_symbol(SYM_HASH);

    // Fill the result path while the receiver holds off; overfill the buffer
    set_timeout(20'hFFFFF);
    tx_idle_on  = 1'b0;
    rx_hold_req = LONG_HOLD;
    for (int k = 0; k < 22; k++) send_symbol(5'(k % 10));
    send_symbol(SYM_H);                    // ignored, buffer full
    send_symbol(SYM_HASH);
    repeat (3) begin
      repeat (8) send_symbol(5'($urandom_range(0, 10)));
      send_symbol(SYM_HASH);
    end
    tx_idle_on = 1'b1;

    // Random part over several timeout settings
    target = live_requests;
    for (int p = 0; p < 7; p++) begin
      set_timeout(timeout_plan[p]);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      target += RANDOM_ITEMS / 7;
      while (live_requests < target) begin
        if ($urandom_range(0, 9) == 0) send_request(2'($urandom), 5'($urandom));
        else send_command_run();
      end
    end

    // Flush whatever is still stored, then let the block settle
    send_request(MODE_FORCE, 5'd0);
    while (results_pending != 0) @(negedge clk);
    repeat (4 * DRAIN_CYCLES) @(negedge clk);

    $display("Summary: %0d requests (%0d acting) under %0d register writes,",
             requests_sent, live_requests, settings_used);
    $display("         %0d command results checked", results_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dcc_pkg.sv
rtl/dcc_ram.sv
rtl/dcc_front.sv
rtl/dcc_queue.sv
rtl/dcc_back.sv
rtl/dtmf_command_collector.sv
rtl/dcc_checker.sv
bench/dcc_result_checker.sv
bench/dtmf_command_collector_tb.sv
